// ===== src/fhc_pkg.sv =====
// Shared types, codes and the byte-wide CRC-32 update for the frame header checker.
// Used by the result interface, the parser, the response queue, the top level and the checker.
package fhc_pkg;

   // framing constants
   localparam int unsigned HDR_BYTES = 44;
   localparam int unsigned ENV_BYTES = 48;
   localparam int unsigned HDR_CRC_SPAN = 22;
   localparam int unsigned HDR_BITS = HDR_BYTES * 8;
   localparam int unsigned POS_W = 25;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_MAGIC       = 3'd0,
      CSR_KNOWN_FLAG_MASK   = 3'd1,
      CSR_MAJOR_VERSION     = 3'd2,
      CSR_MINOR_VERSION     = 3'd3,
      CSR_KIND_LIMIT        = 3'd4,
      CSR_MAX_PAYLOAD_BYTES = 3'd5
   } csr_index_type;

   // result item kinds
   typedef enum logic [1:0] {
      ITEM_ENVELOPE = 2'd0,
      ITEM_PAYLOAD  = 2'd1,
      ITEM_VERDICT  = 2'd2
   } item_kind_type;

   // verdict codes
   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_CLOSED      = 4'd1,
      ST_SHORT_HDR   = 4'd2,
      ST_BAD_MAGIC   = 4'd3,
      ST_BAD_LENGTH  = 4'd4,
      ST_BAD_CRC     = 4'd5,
      ST_BAD_VERSION = 4'd6,
      ST_BAD_FLAGS   = 4'd7,
      ST_BAD_KIND    = 4'd8,
      ST_SHORT_BODY  = 4'd9
   } status_type;

   // everything one input item can produce: at most one data result, then at most one verdict
   typedef struct packed {
      logic              data_vld;
      item_kind_type     data_kind;
      logic [2:0]        word_index;
      logic [63:0]       envelope_word;
      logic [7:0]        payload_byte;
      logic              verd_vld;
      status_type        status;
      logic [15:0]       kind;
      logic [15:0]       flag_bits;
      logic [63:0]       session_high;
      logic [63:0]       session_low;
      logic [POS_W-1:0]  consumed_bytes;
   } entry_type;

   // one result item as shown on the output channel
   typedef struct packed {
      item_kind_type     item_type;
      logic [2:0]        word_index;
      logic [63:0]       envelope_word;
      logic [7:0]        payload_byte;
      status_type        status;
      logic [15:0]       kind;
      logic [15:0]       flag_bits;
      logic [63:0]       session_high;
      logic [63:0]       session_low;
      logic [POS_W-1:0]  consumed_bytes;
      logic              last_of_run;
   } result_type;

   // reflected CRC-32, one byte per call
   function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== src/fhc_req_if.sv =====
// Input channel of the frame header checker: one receive-buffer byte per item.
// Depends on nothing but the valid/ready handshake.
interface fhc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       buffer_end;

   modport source (output valid, output data_byte, output byte_present, output buffer_end,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_present, input buffer_end,
                   output ready);
endinterface

// ===== src/fhc_rsp_if.sv =====
// Result channel of the frame header checker: envelope words, payload bytes, verdicts.
// Field widths follow fhc_pkg.
interface fhc_rsp_if;
   import fhc_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        item_type;
   logic [2:0]        word_index;
   logic [63:0]       envelope_word;
   logic [7:0]        payload_byte;
   logic [3:0]        status;
   logic [15:0]       kind;
   logic [15:0]       flag_bits;
   logic [63:0]       session_high;
   logic [63:0]       session_low;
   logic [POS_W-1:0]  consumed_bytes;
   logic              last_of_run;

   modport source (output valid, output item_type, output word_index, output envelope_word,
                   output payload_byte, output status, output kind, output flag_bits,
                   output session_high, output session_low, output consumed_bytes,
                   output last_of_run, input ready);
   modport sink   (input valid, input item_type, input word_index, input envelope_word,
                   input payload_byte, input status, input kind, input flag_bits,
                   input session_high, input session_low, input consumed_bytes,
                   input last_of_run, output ready);
endinterface

// ===== src/fhc_parser.sv =====
// Frame parser: header shift line, CRC, header checks, envelope gathering, verdicts.
// Depends on fhc_pkg. Produces at most one queue entry per accepted input item.
module fhc_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              byte_present,
   input  logic              buffer_end,
   input  logic [31:0]       frame_magic,
   input  logic [15:0]       known_flag_mask,
   input  logic [15:0]       major_version,
   input  logic [15:0]       minor_version,
   input  logic [15:0]       kind_limit,
   input  logic [23:0]       max_payload_bytes,
   output logic              push,
   output fhc_pkg::entry_type push_entry
);
   import fhc_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_BODY    = 3'b010,
      PH_DISCARD = 3'b100
   } phase_type;

   localparam logic [POS_W-1:0] LAST_HDR_POS = POS_W'(HDR_BYTES - 1);
   localparam logic [POS_W-1:0] CRC_SPAN_POS = POS_W'(HDR_CRC_SPAN);
   localparam logic [POS_W-1:0] BODY_START   = POS_W'(HDR_BYTES);
   localparam logic [POS_W-1:0] ENV_END_POS  = POS_W'(HDR_BYTES + ENV_BYTES);

   phase_type            phase_ff, phase_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [31:0]          crc_ff, crc_in;
   logic [HDR_BITS-1:0]  hdr_ff, hdr_in;
   logic [55:0]          env_ff, env_in;
   logic [POS_W-1:0]     end_pos_ff, end_pos_in;

   logic [HDR_BITS-1:0]  hdr_shift;
   status_type           hdr_status;
   logic [31:0]          crc_body;
   logic [POS_W-1:0]     body_off;
   logic [POS_W-1:0]     len_limit;
   entry_type            entry;

   // header fields, little-endian, once all header bytes have been shifted in
   logic [31:0] f_magic, f_blen, f_hcrc;
   logic [15:0] f_hsize, f_kind, f_flags, f_major, f_minor, f_resv;

   assign hdr_shift = {data_byte, hdr_ff[HDR_BITS-1:8]};
   assign f_magic   = hdr_shift[31:0];
   assign f_hsize   = hdr_shift[47:32];
   assign f_kind    = hdr_shift[63:48];
   assign f_flags   = hdr_shift[79:64];
   assign f_major   = hdr_shift[95:80];
   assign f_minor   = hdr_shift[111:96];
   assign f_blen    = hdr_shift[143:112];
   assign f_hcrc    = hdr_shift[207:176];
   assign f_resv    = hdr_shift[223:208];

   assign len_limit = {1'b0, max_payload_bytes} + POS_W'(ENV_BYTES);
   assign crc_body  = crc32_feed(crc_ff, data_byte);
   assign body_off  = pos_ff - BODY_START;

   // header checks in their fixed order; header CRC is complete before the last byte
   always_comb begin
      priority if (f_magic != frame_magic)                    hdr_status = ST_BAD_MAGIC;
      else if (f_hsize != 16'(HDR_BYTES))                     hdr_status = ST_BAD_LENGTH;
      else if ((crc_ff ^ CRC_INIT) != f_hcrc)                 hdr_status = ST_BAD_CRC;
      else if (f_major != major_version)                      hdr_status = ST_BAD_VERSION;
      else if (f_minor > minor_version)                       hdr_status = ST_BAD_VERSION;
      else if (f_resv != 16'd0)                               hdr_status = ST_BAD_FLAGS;
      else if ((f_flags & ~known_flag_mask) != 16'd0)         hdr_status = ST_BAD_FLAGS;
      else if (f_kind == 16'd0 || f_kind >= kind_limit)       hdr_status = ST_BAD_KIND;
      else if (f_blen < 32'(ENV_BYTES))                       hdr_status = ST_BAD_LENGTH;
      else if (f_blen > {7'd0, len_limit})                    hdr_status = ST_BAD_LENGTH;
      else                                                    hdr_status = ST_OK;
   end

   // next state and the entry for this item
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      hdr_in     = hdr_ff;
      env_in     = env_ff;
      end_pos_in = end_pos_ff;
      entry      = '0;

      if (accept) begin
         if (byte_present) begin
            unique case (phase_ff)
               PH_HEADER: begin
                  hdr_in = hdr_shift;
                  if (pos_ff < CRC_SPAN_POS) crc_in = crc_body;
                  pos_in = pos_ff + 1'b1;
                  if (pos_ff == LAST_HDR_POS) begin
                     if (hdr_status != ST_OK) begin
                        entry.verd_vld = 1'b1;
                        entry.status   = hdr_status;
                        phase_in       = PH_DISCARD;
                     end else begin
                        end_pos_in = f_blen[POS_W-1:0] + BODY_START;
                        crc_in     = CRC_INIT;
                        phase_in   = PH_BODY;
                     end
                  end
               end
               PH_BODY: begin
                  crc_in = crc_body;
                  if (pos_ff < ENV_END_POS) begin
                     env_in = {data_byte, env_ff[55:8]};
                     if (body_off[2:0] == 3'd7) begin
                        entry.data_vld      = 1'b1;
                        entry.data_kind     = ITEM_ENVELOPE;
                        entry.word_index    = body_off[5:3];
                        entry.envelope_word = {data_byte, env_ff};
                     end
                  end else begin
                     entry.data_vld     = 1'b1;
                     entry.data_kind    = ITEM_PAYLOAD;
                     entry.payload_byte = data_byte;
                  end
                  pos_in = pos_ff + 1'b1;
                  // last body byte: body CRC verdict
                  if (pos_in == end_pos_ff) begin
                     entry.verd_vld     = 1'b1;
                     entry.kind         = hdr_ff[63:48];
                     entry.flag_bits    = hdr_ff[79:64];
                     entry.session_high = hdr_ff[287:224];
                     entry.session_low  = hdr_ff[351:288];
                     if ((crc_body ^ CRC_INIT) == hdr_ff[175:144]) begin
                        entry.status         = ST_OK;
                        entry.consumed_bytes = pos_in;
                     end else begin
                        entry.status = ST_BAD_CRC;
                     end
                     phase_in = PH_HEADER;
                     pos_in   = '0;
                     crc_in   = CRC_INIT;
                  end
               end
               PH_DISCARD: begin
               end
               default: begin
               end
            endcase
         end

         // end of buffer: report an unfinished frame or a closed empty buffer, then wait for a new header
         if (buffer_end) begin
            unique case (phase_in)
               PH_BODY: begin
                  entry.verd_vld     = 1'b1;
                  entry.status       = ST_SHORT_BODY;
                  entry.kind         = hdr_in[63:48];
                  entry.flag_bits    = hdr_in[79:64];
                  entry.session_high = hdr_in[287:224];
                  entry.session_low  = hdr_in[351:288];
               end
               PH_HEADER: begin
                  if (pos_in != '0) begin
                     entry.verd_vld = 1'b1;
                     entry.status   = ST_SHORT_HDR;
                  end else if (!byte_present) begin
                     entry.verd_vld = 1'b1;
                     entry.status   = ST_CLOSED;
                  end
               end
               PH_DISCARD: begin
               end
               default: begin
               end
            endcase
            phase_in = PH_HEADER;
            pos_in   = '0;
            crc_in   = CRC_INIT;
         end
      end
   end

   assign push       = accept && (entry.data_vld || entry.verd_vld);
   assign push_entry = entry;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
      end
   end

   // header bytes, envelope bytes and frame end position
   always_ff @(posedge clock) begin
      hdr_ff     <= hdr_in;
      env_ff     <= env_in;
      end_pos_ff <= end_pos_in;
   end

endmodule

// ===== src/fhc_rsp_queue.sv =====
// Two-entry result queue: each entry holds the results of one input item
// (an optional data result, then an optional verdict). Depends on fhc_pkg.
module fhc_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fhc_pkg::entry_type  push_entry,
   output logic                full,
   output logic                out_valid,
   input  logic                out_ready,
   output fhc_pkg::result_type out_result
);
   import fhc_pkg::*;

   entry_type   ent_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        sub_ff, sub_in;

   entry_type   head;
   logic        show_data;
   logic        last_part;
   logic        fire;
   logic        pop;

   assign head      = ent_ff[rd_ptr_ff];
   assign show_data = head.data_vld && !sub_ff;
   assign last_part = show_data ? !head.verd_vld : 1'b1;
   assign out_valid = (cnt_ff != 2'd0);
   assign fire      = out_valid && out_ready;
   assign pop       = fire && last_part;
   assign full      = (cnt_ff == 2'd2);

   // present the data result first, the verdict second
   always_comb begin
      out_result             = '0;
      out_result.last_of_run = last_part;
      if (show_data) begin
         out_result.item_type     = head.data_kind;
         out_result.word_index    = head.word_index;
         out_result.envelope_word = head.envelope_word;
         out_result.payload_byte  = head.payload_byte;
      end else begin
         out_result.item_type      = ITEM_VERDICT;
         out_result.status         = head.status;
         out_result.kind           = head.kind;
         out_result.flag_bits      = head.flag_bits;
         out_result.session_high   = head.session_high;
         out_result.session_low    = head.session_low;
         out_result.consumed_bytes = head.consumed_bytes;
      end
   end

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      if (pop)       sub_in = 1'b0;
      else if (fire) sub_in = 1'b1;
      else           sub_in = sub_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         sub_ff    <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         sub_ff <= sub_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== src/frame_header_checker.sv =====
// Frame header checker: one receive byte per item in, envelope words, payload bytes
// and frame verdicts out. Each item's results are registered in the result queue before they are shown.
// Throughput: one item per cycle while the queue is not full; an item with two results shows its data result,
// then its verdict, and a two-entry result queue keeps input ready while results wait (ready = queue not full).
// Reset (synchronous, active high) clears the queue and parser, awaits a header and
// loads the register reset values.
module frame_header_checker (
   input  logic                            clock,
   input  logic                            reset,
   fhc_req_if.sink                         req_chan,
   fhc_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [fhc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fhc_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import fhc_pkg::*;

   logic [31:0] frame_magic_ff;
   logic [15:0] known_flag_mask_ff;
   logic [15:0] major_version_ff;
   logic [15:0] minor_version_ff;
   logic [15:0] kind_limit_ff;
   logic [23:0] max_payload_bytes_ff;

   logic        accept;
   logic        push;
   entry_type   push_entry;
   logic        full;
   result_type  result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_magic_ff       <= 32'd0;
         known_flag_mask_ff   <= 16'd0;
         major_version_ff     <= 16'd1;
         minor_version_ff     <= 16'd0;
         kind_limit_ff        <= 16'd25;
         max_payload_bytes_ff <= 24'd1048576;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_MAGIC:       frame_magic_ff       <= csr_wr_data;
            CSR_KNOWN_FLAG_MASK:   known_flag_mask_ff   <= csr_wr_data[15:0];
            CSR_MAJOR_VERSION:     major_version_ff     <= csr_wr_data[15:0];
            CSR_MINOR_VERSION:     minor_version_ff     <= csr_wr_data[15:0];
            CSR_KIND_LIMIT:        kind_limit_ff        <= csr_wr_data[15:0];
            CSR_MAX_PAYLOAD_BYTES: max_payload_bytes_ff <= csr_wr_data[23:0];
            default: begin
            end
         endcase
      end
   end

   // input handshake
   assign req_chan.ready = !full;
   assign accept         = req_chan.valid && !full;

   fhc_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .data_byte         (req_chan.data_byte),
      .byte_present      (req_chan.byte_present),
      .buffer_end        (req_chan.buffer_end),
      .frame_magic       (frame_magic_ff),
      .known_flag_mask   (known_flag_mask_ff),
      .major_version     (major_version_ff),
      .minor_version     (minor_version_ff),
      .kind_limit        (kind_limit_ff),
      .max_payload_bytes (max_payload_bytes_ff),
      .push              (push),
      .push_entry        (push_entry)
   );

   fhc_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_result (result)
   );

   // result fields
   assign rsp_chan.item_type      = result.item_type;
   assign rsp_chan.word_index     = result.word_index;
   assign rsp_chan.envelope_word  = result.envelope_word;
   assign rsp_chan.payload_byte   = result.payload_byte;
   assign rsp_chan.status         = result.status;
   assign rsp_chan.kind           = result.kind;
   assign rsp_chan.flag_bits      = result.flag_bits;
   assign rsp_chan.session_high   = result.session_high;
   assign rsp_chan.session_low    = result.session_low;
   assign rsp_chan.consumed_bytes = result.consumed_bytes;
   assign rsp_chan.last_of_run    = result.last_of_run;

endmodule

// ===== src/fhc_checker.sv =====
// Port-level checks on the result channel of frame_header_checker, bound to the top level.
// Depends on fhc_pkg for item and status codes.
module fhc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               rsp_item_type,
   input logic [2:0]               rsp_word_index,
   input logic [63:0]              rsp_envelope_word,
   input logic [3:0]               rsp_status,
   input logic [fhc_pkg::POS_W-1:0] rsp_consumed_bytes
);
   import fhc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_type)
         && $stable(rsp_envelope_word) && $stable(rsp_status))
      else $error("result changed while stalled");

   // only an ok verdict reports consumed bytes
   a_err_no_consumed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_type == ITEM_VERDICT && rsp_status != ST_OK
         |-> rsp_consumed_bytes == '0)
      else $error("failed verdict with consumed bytes");

   // an ok frame covers at least the header and envelope
   a_ok_min_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_type == ITEM_VERDICT && rsp_status == ST_OK
         |-> rsp_consumed_bytes >= POS_W'(HDR_BYTES + ENV_BYTES))
      else $error("ok verdict shorter than header and envelope");

   // six envelope words per frame
   a_word_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_type == ITEM_ENVELOPE |-> rsp_word_index <= 3'd5)
      else $error("envelope word index out of range");

endmodule

bind frame_header_checker fhc_checker u_fhc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_item_type      (rsp_chan.item_type),
   .rsp_word_index     (rsp_chan.word_index),
   .rsp_envelope_word  (rsp_chan.envelope_word),
   .rsp_status         (rsp_chan.status),
   .rsp_consumed_bytes (rsp_chan.consumed_bytes)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for frame_header_checker: random framed byte streams in,
// results checked against an in-bench deframer. Depends on fhc_pkg and the two channel
// interfaces from the RTL sources.
module testbench;
   import fhc_pkg::*;

   // parser phases of the in-bench deframer
   typedef enum logic [1:0] {
      AWAIT_HEADER,
      IN_BODY,
      DISCARDING
   } parse_phase_type;

   // frame shapes the stimulus builder can produce
   typedef enum int {
      FR_GOOD,
      FR_BAD_MAGIC,
      FR_BAD_SIZE,
      FR_BAD_HDR_CRC,
      FR_BAD_MAJOR,
      FR_BAD_MINOR,
      FR_BAD_RESERVED,
      FR_BAD_FLAGS,
      FR_BAD_KIND,
      FR_SHORT_BLEN,
      FR_LONG_BLEN,
      FR_BAD_BODY_CRC,
      FR_CUT_HEADER,
      FR_CUT_BODY,
      FR_NOISE,
      NUM_SHAPES
   } frame_shape_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       buffer_end;
   } rx_item_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   fhc_req_if req_bus ();
   fhc_rsp_if rsp_bus ();

   frame_header_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // register copies, tracking every write
   logic [31:0] magic_reg;
   logic [15:0] flag_mask_reg;
   logic [15:0] major_reg;
   logic [15:0] minor_reg;
   logic [15:0] kind_limit_reg;
   logic [23:0] max_payload_reg;

   // deframer state
   parse_phase_type frame_state;
   logic [POS_W-1:0] frame_pos;
   logic [7:0]       hdr_bytes [HDR_BYTES];
   logic [31:0]      run_crc;
   logic [31:0]      body_len;
   logic [63:0]      env_word;

   rx_item_type rx_pending [$];
   result_type  frame_results_due [$];
   rx_item_type offer;
   bit          offer_held;
   int          req_idle_pct;
   int          rsp_stall_pct;
   int          items_queued;
   int          frames_built;
   int          results_checked;
   int          mismatch_count;

   // ---------------------------------------------------------------- deframer

   function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      int i;
      r = crc;
      for (i = 0; i < 8; i++) begin
         if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
         else r = r >> 1;
      end
      return r;
   endfunction

   function automatic logic [15:0] hdr16(input int off);
      return {hdr_bytes[off+1], hdr_bytes[off]};
   endfunction

   function automatic logic [31:0] hdr32(input int off);
      return {hdr16(off + 2), hdr16(off)};
   endfunction

   function automatic logic [63:0] hdr64(input int off);
      return {hdr32(off + 4), hdr32(off)};
   endfunction

   // header checks, first failure wins
   function automatic status_type header_verdict();
      logic [15:0] kind;
      logic [31:0] blen;
      kind = hdr16(6);
      blen = hdr32(14);
      if (hdr32(0) != magic_reg) return ST_BAD_MAGIC;
      if (hdr16(4) != 16'(HDR_BYTES)) return ST_BAD_LENGTH;
      if (~run_crc != hdr32(22)) return ST_BAD_CRC;
      if (hdr16(10) != major_reg) return ST_BAD_VERSION;
      if (hdr16(12) > minor_reg) return ST_BAD_VERSION;
      if (hdr16(26) != 16'd0) return ST_BAD_FLAGS;
      if ((hdr16(8) & ~flag_mask_reg) != 16'd0) return ST_BAD_FLAGS;
      if (kind == 16'd0 || kind >= kind_limit_reg) return ST_BAD_KIND;
      if (blen < ENV_BYTES) return ST_BAD_LENGTH;
      if (blen > 32'(max_payload_reg) + ENV_BYTES) return ST_BAD_LENGTH;
      return ST_OK;
   endfunction

   function automatic result_type verdict_item(input status_type st, input bit with_hdr,
                                               input logic [POS_W-1:0] consumed);
      result_type r;
      r = '0;
      r.item_type = ITEM_VERDICT;
      r.status = st;
      r.consumed_bytes = consumed;
      if (with_hdr) begin
         r.kind = hdr16(6);
         r.flag_bits = hdr16(8);
         r.session_high = hdr64(28);
         r.session_low = hdr64(36);
      end
      return r;
   endfunction

   task automatic restart_frame();
      frame_state = AWAIT_HEADER;
      frame_pos = '0;
      run_crc = CRC_INIT;
      env_word = '0;
   endtask

   // one accepted item: advance the deframer and queue the results it causes
   task automatic deframe_step(input rx_item_type it);
      result_type outs [2];
      int n;
      int i;
      logic [31:0] k;
      n = 0;
      if (it.byte_present) begin
         case (frame_state)
            AWAIT_HEADER: begin
               hdr_bytes[frame_pos[5:0]] = it.data_byte;
               if (frame_pos < HDR_CRC_SPAN) run_crc = crc_shift_byte(run_crc, it.data_byte);
               frame_pos = frame_pos + 1'b1;
               if (frame_pos == HDR_BYTES) begin
                  if (header_verdict() != ST_OK) begin
                     outs[n] = verdict_item(header_verdict(), 1'b0, '0);
                     n++;
                     frame_state = DISCARDING;
                  end else begin
                     body_len = hdr32(14);
                     run_crc = CRC_INIT;
                     env_word = '0;
                     frame_state = IN_BODY;
                  end
               end
            end
            IN_BODY: begin
               k = frame_pos - HDR_BYTES;
               run_crc = crc_shift_byte(run_crc, it.data_byte);
               if (k < ENV_BYTES) begin
                  env_word[k[2:0]*8 +: 8] = it.data_byte;
                  if (k[2:0] == 3'd7) begin
                     outs[n] = '0;
                     outs[n].item_type = ITEM_ENVELOPE;
                     outs[n].word_index = k[5:3];
                     outs[n].envelope_word = env_word;
                     n++;
                     env_word = '0;
                  end
               end else begin
                  outs[n] = '0;
                  outs[n].item_type = ITEM_PAYLOAD;
                  outs[n].payload_byte = it.data_byte;
                  n++;
               end
               frame_pos = frame_pos + 1'b1;
               if (frame_pos - HDR_BYTES == body_len) begin
                  if (~run_crc == hdr32(18)) outs[n] = verdict_item(ST_OK, 1'b1, frame_pos);
                  else outs[n] = verdict_item(ST_BAD_CRC, 1'b1, '0);
                  n++;
                  restart_frame();
               end
            end
            default: ;
         endcase
      end
      // buffer end closes whatever is open
      if (it.buffer_end) begin
         if (frame_state == IN_BODY) begin
            outs[n] = verdict_item(ST_SHORT_BODY, 1'b1, '0);
            n++;
         end else if (frame_state == AWAIT_HEADER && frame_pos != 0) begin
            outs[n] = verdict_item(ST_SHORT_HDR, 1'b0, '0);
            n++;
         end else if (frame_state == AWAIT_HEADER && !it.byte_present) begin
            outs[n] = verdict_item(ST_CLOSED, 1'b0, '0);
            n++;
         end
         restart_frame();
      end
      if (n > 0) outs[n-1].last_of_run = 1'b1;
      for (i = 0; i < n; i++) frame_results_due = {frame_results_due, outs[i]};
   endtask

   // ---------------------------------------------------------------- stimulus builders

   task automatic queue_item(input logic [7:0] d, input logic present, input logic fin);
      rx_item_type it;
      it.data_byte = d;
      it.byte_present = present;
      it.buffer_end = fin;
      rx_pending = {rx_pending, it};
      if (present || fin) items_queued++;
   endtask

   // data byte, now and then preceded by an idle item
   task automatic push_byte(input logic [7:0] b);
      if ($urandom_range(19) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
      queue_item(b, 1'b1, 1'b0);
   endtask

   // end the buffer on the last byte or with an end-only item
   task automatic close_buffer();
      rx_item_type it;
      if (rx_pending.size() > 0 && rx_pending[$].byte_present && !rx_pending[$].buffer_end
          && $urandom_range(1) == 1) begin
         it = rx_pending.pop_back();
         it.buffer_end = 1'b1;
         rx_pending = {rx_pending, it};
      end else begin
         queue_item(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   task automatic queue_frame(input frame_shape_type shape);
      logic [7:0]  hb [HDR_BYTES];
      logic [7:0]  body [$];
      logic [31:0] magic, blen, hcrc, bcrc, plen;
      logic [15:0] size_field, kind, flags, major, minor, reserved;
      int i, cut, bit_no;

      magic = magic_reg;
      size_field = 16'(HDR_BYTES);
      major = major_reg;
      minor = 16'($urandom_range(minor_reg, 0));
      kind = (kind_limit_reg > 1) ? 16'($urandom_range(kind_limit_reg - 1, 1)) : 16'd1;
      flags = 16'($urandom) & flag_mask_reg;
      reserved = '0;

      // mostly short payloads, sometimes exactly at the length bound
      plen = $urandom_range(12, 0);
      if (plen > max_payload_reg || (max_payload_reg <= 12 && $urandom_range(4) == 0))
         plen = 32'(max_payload_reg);
      blen = ENV_BYTES + plen;
      for (i = 0; i < blen; i++) body = {body, 8'($urandom)};
      bcrc = CRC_INIT;
      for (i = 0; i < blen; i++) bcrc = crc_shift_byte(bcrc, body[i]);
      bcrc = ~bcrc;

      case (shape)
         FR_BAD_MAGIC:    magic ^= 32'd1 << $urandom_range(31);
         FR_BAD_SIZE:     size_field ^= 16'd1 << $urandom_range(15);
         FR_BAD_MAJOR:    major ^= 16'd1 << $urandom_range(15);
         FR_BAD_MINOR:    if (minor_reg != 16'hFFFF)
                             minor = 16'($urandom_range(32'hFFFF, 32'(minor_reg) + 32'd1));
         FR_BAD_RESERVED: reserved = 16'd1 << $urandom_range(15);
         FR_BAD_FLAGS: begin
            if (flag_mask_reg == 16'hFFFF) begin
               reserved = 16'h8000;
            end else begin
               do bit_no = $urandom_range(15); while (flag_mask_reg[bit_no]);
               flags[bit_no] = 1'b1;
            end
         end
         FR_BAD_KIND:     kind = ($urandom_range(1) == 0) ? 16'd0
                                 : 16'($urandom_range(32'hFFFF, kind_limit_reg));
         FR_SHORT_BLEN:   blen = $urandom_range(ENV_BYTES - 1, 0);
         FR_LONG_BLEN:    blen = $urandom_range(1) ? 32'hFFFF_FFFF
                                 : 32'(max_payload_reg) + ENV_BYTES + 1 + $urandom_range(3);
         FR_BAD_BODY_CRC: bcrc ^= 32'd1 << $urandom_range(31);
         default: ;
      endcase

      // little-endian header image
      {hb[3], hb[2], hb[1], hb[0]} = magic;
      {hb[5], hb[4]} = size_field;
      {hb[7], hb[6]} = kind;
      {hb[9], hb[8]} = flags;
      {hb[11], hb[10]} = major;
      {hb[13], hb[12]} = minor;
      {hb[17], hb[16], hb[15], hb[14]} = blen;
      {hb[21], hb[20], hb[19], hb[18]} = bcrc;
      hcrc = CRC_INIT;
      for (i = 0; i < HDR_CRC_SPAN; i++) hcrc = crc_shift_byte(hcrc, hb[i]);
      hcrc = ~hcrc;
      if (shape == FR_BAD_HDR_CRC) hcrc ^= 32'd1 << $urandom_range(31);
      {hb[25], hb[24], hb[23], hb[22]} = hcrc;
      {hb[27], hb[26]} = reserved;
      for (i = 28; i < HDR_BYTES; i++) hb[i] = 8'($urandom);

      case (shape)
         FR_NOISE: begin
            cut = $urandom_range(60, 1);
            for (i = 0; i < cut; i++) push_byte(8'($urandom));
            close_buffer();
         end
         FR_CUT_HEADER: begin
            cut = $urandom_range(HDR_BYTES - 1, 1);
            for (i = 0; i < cut; i++) push_byte(hb[i]);
            close_buffer();
         end
         FR_GOOD, FR_BAD_BODY_CRC, FR_CUT_BODY: begin
            for (i = 0; i < HDR_BYTES; i++) push_byte(hb[i]);
            cut = (shape == FR_CUT_BODY) ? $urandom_range(blen - 1, 0) : blen;
            for (i = 0; i < cut; i++) push_byte(body[i]);
            // whole frames may share a buffer with the next one
            if (shape == FR_CUT_BODY || $urandom_range(1) == 1) close_buffer();
         end
         default: begin
            // header error: some trailing bytes get discarded up to the buffer end
            for (i = 0; i < HDR_BYTES; i++) push_byte(hb[i]);
            cut = $urandom_range(6, 0);
            for (i = 0; i < cut; i++) push_byte(8'($urandom));
            close_buffer();
         end
      endcase
   endtask

   function automatic frame_shape_type pick_shape();
      if (frames_built < NUM_SHAPES) return frame_shape_type'(frames_built);
      if ($urandom_range(99) < 55) return FR_GOOD;
      return frame_shape_type'($urandom_range(NUM_SHAPES - 1, 1));
   endfunction

   // ---------------------------------------------------------------- register writes

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_FRAME_MAGIC:       magic_reg = value;
         CSR_KNOWN_FLAG_MASK:   flag_mask_reg = value[15:0];
         CSR_MAJOR_VERSION:     major_reg = value[15:0];
         CSR_MINOR_VERSION:     minor_reg = value[15:0];
         CSR_KIND_LIMIT:        kind_limit_reg = value[15:0];
         CSR_MAX_PAYLOAD_BYTES: max_payload_reg = value[23:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int which);
      case (which)
         2: begin
            csr_write(CSR_FRAME_MAGIC, 32'hFFFF_FFFF);
            csr_write(CSR_KNOWN_FLAG_MASK, 32'hFFFF);
            csr_write(CSR_MAJOR_VERSION, 32'hFFFF);
            csr_write(CSR_MINOR_VERSION, 32'hFFFF);
            csr_write(CSR_KIND_LIMIT, 32'hFFFF);
            csr_write(CSR_MAX_PAYLOAD_BYTES, 32'hFF_FFFF);
         end
         4: begin
            csr_write(CSR_FRAME_MAGIC, 32'd0);
            csr_write(CSR_KNOWN_FLAG_MASK, 32'd0);
            csr_write(CSR_MAJOR_VERSION, 32'd0);
            csr_write(CSR_MINOR_VERSION, 32'd0);
            csr_write(CSR_KIND_LIMIT, 32'd1);
            csr_write(CSR_MAX_PAYLOAD_BYTES, 32'd0);
         end
         default: begin
            csr_write(CSR_FRAME_MAGIC, $urandom);
            csr_write(CSR_KNOWN_FLAG_MASK, $urandom_range(32'hFFFF));
            csr_write(CSR_MAJOR_VERSION, $urandom_range(32'hFFFF));
            csr_write(CSR_MINOR_VERSION, $urandom_range(32'hFFFF));
            csr_write(CSR_KIND_LIMIT, $urandom_range(40, 2));
            csr_write(CSR_MAX_PAYLOAD_BYTES, $urandom_range(24, 1));
         end
      endcase
   endtask

   // ---------------------------------------------------------------- drain helpers

   function automatic bit drained();
      return rx_pending.size() == 0 && !offer_held && frame_results_due.size() == 0;
   endfunction

   // an idle item causes no result, so keep clocking after nothing is due
   task automatic wait_drained();
      while (!drained()) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   // new item or idle at the falling edge; a held item stays until taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!offer_held && rx_pending.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            offer = rx_pending.pop_front();
            offer_held = 1'b1;
            req_bus.valid <= 1'b1;
            req_bus.data_byte <= offer.data_byte;
            req_bus.byte_present <= offer.byte_present;
            req_bus.buffer_end <= offer.buffer_end;
         end else if (!offer_held) begin
            req_bus.valid <= 1'b0;
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // item taken: predict what it causes
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         deframe_step(offer);
         offer_held = 1'b0;
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("testbench: mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                   results_checked, name, got, want));
   endtask

   always @(posedge clock) begin : result_monitor
      result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         if (frame_results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result, type %0d", rsp_bus.item_type));
         end else begin
            want = frame_results_due.pop_front();
            check_field("item_type", 64'(rsp_bus.item_type), 64'(want.item_type));
            check_field("word_index", 64'(rsp_bus.word_index), 64'(want.word_index));
            check_field("envelope_word", rsp_bus.envelope_word, want.envelope_word);
            check_field("payload_byte", 64'(rsp_bus.payload_byte), 64'(want.payload_byte));
            check_field("status", 64'(rsp_bus.status), 64'(want.status));
            check_field("kind", 64'(rsp_bus.kind), 64'(want.kind));
            check_field("flag_bits", 64'(rsp_bus.flag_bits), 64'(want.flag_bits));
            check_field("session_high", rsp_bus.session_high, want.session_high);
            check_field("session_low", rsp_bus.session_low, want.session_low);
            check_field("consumed_bytes", 64'(rsp_bus.consumed_bytes),
                        64'(want.consumed_bytes));
            check_field("last_of_run", 64'(rsp_bus.last_of_run), 64'(want.last_of_run));
         end
         results_checked++;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int setting;
      int target;
      int guard;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_FRAME_MAGIC;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.byte_present = 1'b0;
      req_bus.buffer_end = 1'b0;
      rsp_bus.ready = 1'b0;

      // register values after reset
      magic_reg = '0;
      flag_mask_reg = '0;
      major_reg = 16'd1;
      minor_reg = '0;
      kind_limit_reg = 16'd25;
      max_payload_reg = 24'd1048576;
      body_len = '0;
      restart_frame();

      offer_held = 1'b0;
      items_queued = 0;
      frames_built = 0;
      results_checked = 0;
      mismatch_count = 0;
      req_idle_pct = 28;
      rsp_stall_pct = 28;

      // short directed run: idle, closed buffer, short headers, extreme bytes
      queue_item(8'h5A, 1'b0, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'hFF, 1'b1, 1'b1);
      queue_item(8'h00, 1'b1, 1'b0);
      queue_item(8'h80, 1'b1, 1'b0);
      queue_item(8'hA5, 1'b0, 1'b1);
      queue_item(8'hFF, 1'b0, 1'b1);
      queue_item(8'h7F, 1'b0, 1'b0);
      queue_item(8'h01, 1'b1, 1'b0);
      queue_item(8'hFE, 1'b0, 1'b1);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register settings: reset values, random, all high, random without idling, all low
      for (setting = 0; setting < 5; setting++) begin
         if (setting > 0) begin
            wait_drained();
            apply_setting(setting);
         end
         req_idle_pct = (setting == 3) ? 0 : 28;
         rsp_stall_pct = (setting == 3) ? 0 : 28;
         target = items_queued + 240;
         while (items_queued < target) begin
            queue_frame(pick_shape());
            frames_built++;
         end
      end

      for (guard = 0; guard < 50000 && !drained(); guard++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (frame_results_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", frame_results_due.size()));
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
